// File: rtl/core/tcsd_pkg.sv
// ----------------------------------------------------------------------------
// tcsd_pkg
// types, widths and codes shared by the column span and depth block
// ----------------------------------------------------------------------------
package tcsd_pkg;

   localparam int COORD_BITS      = 12;
   localparam int DEPTH_FRAC_DEF  = 16;
   localparam int ZERO_AREA_DEPTH = 2;
   localparam int DEPTH_BITS      = 32;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int AREA_W  = PROD_W + 1;
   localparam int ZDIFF_W = DEPTH_BITS + 1;
   localparam int NUM_W   = ZDIFF_W + AREA_W + 1;
   localparam int CNT_W   = $clog2(NUM_W + 1);

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [1:0] SLOT_NONE = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_FLAT    = 2'd2;

   localparam logic [1:0] OP_MUL       = 2'd0;
   localparam logic [1:0] OP_DIV_SHORT = 2'd1;
   localparam logic [1:0] OP_DIV_LONG  = 2'd2;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [ST_W-1:0] ST_SORT    = 5'd1;
   localparam logic [ST_W-1:0] ST_CHECK   = 5'd2;
   localparam logic [ST_W-1:0] ST_E1_MUL  = 5'd3;
   localparam logic [ST_W-1:0] ST_E1_GO   = 5'd4;
   localparam logic [ST_W-1:0] ST_E1_WAIT = 5'd5;
   localparam logic [ST_W-1:0] ST_E2_MUL  = 5'd6;
   localparam logic [ST_W-1:0] ST_E2_GO   = 5'd7;
   localparam logic [ST_W-1:0] ST_E2_WAIT = 5'd8;
   localparam logic [ST_W-1:0] ST_SPAN    = 5'd9;
   localparam logic [ST_W-1:0] ST_AREA1   = 5'd10;
   localparam logic [ST_W-1:0] ST_AREA2   = 5'd11;
   localparam logic [ST_W-1:0] ST_ACHK    = 5'd12;
   localparam logic [ST_W-1:0] ST_NA1     = 5'd13;
   localparam logic [ST_W-1:0] ST_NA2     = 5'd14;
   localparam logic [ST_W-1:0] ST_NB1     = 5'd15;
   localparam logic [ST_W-1:0] ST_NB2     = 5'd16;
   localparam logic [ST_W-1:0] ST_ZA_GO   = 5'd17;
   localparam logic [ST_W-1:0] ST_ZA_WAIT = 5'd18;
   localparam logic [ST_W-1:0] ST_ZB_GO   = 5'd19;
   localparam logic [ST_W-1:0] ST_ZB_WAIT = 5'd20;
   localparam logic [ST_W-1:0] ST_DV_GO   = 5'd21;
   localparam logic [ST_W-1:0] ST_DV_WAIT = 5'd22;
   localparam logic [ST_W-1:0] ST_EMIT    = 5'd23;

   typedef struct packed {
      logic                          mode;
      logic [1:0]                    vertex_slot;
      logic signed [COORD_BITS-1:0]  vertex_x;
      logic signed [COORD_BITS-1:0]  vertex_y;
      logic signed [DEPTH_BITS-1:0]  vertex_depth;
      logic signed [COORD_BITS-1:0]  query_x;
      logic signed [COORD_BITS-1:0]  query_y;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  span_low;
      logic signed [COORD_BITS-1:0]  span_high;
      logic signed [DEPTH_BITS-1:0]  depth;
      logic [1:0]                    status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic signed [DEPTH_BITS-1:0]  z;
   } corner_type;

   typedef struct packed {
      logic             load;
      logic             capture;
      logic [ST_W-1:0]  step;
   } cmd_type;

   typedef struct packed {
      logic outside;
      logic vertical;
      logic below_b;
      logic b_eq_c;
      logic area_zero;
      logic unit_done;
      logic out_busy;
   } stat_type;

   function automatic logic signed [DIFF_W-1:0] coord_diff(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] q
   );
      return DIFF_W'(p) - DIFF_W'(q);
   endfunction

endpackage

// File: rtl/core/tcsd_arith.sv
// ----------------------------------------------------------------------------
// tcsd_arith
// shared iterative unit: signed shift-add multiply and restoring divide,
// one bit per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
module tcsd_arith (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         op,
   input  logic signed [tcsd_pkg::NUM_W-1:0]  opa,
   input  logic signed [tcsd_pkg::AREA_W-1:0] opb,
   output logic                               done,
   output logic signed [tcsd_pkg::NUM_W-1:0]  result
);
   import tcsd_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic              is_div_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NUM_W-1:0]  acc_ff;
   logic [NUM_W-1:0]  mcand_ff;
   logic [AREA_W-1:0] mb_ff;
   logic [AREA_W-1:0] rem_ff;

   logic [NUM_W-1:0]  ma;
   logic [AREA_W-1:0] mbm;
   logic [AREA_W:0]   trial;
   logic              fits;

   assign ma    = opa[NUM_W-1] ? NUM_W'(-opa) : NUM_W'(opa);
   assign mbm   = opb[AREA_W-1] ? AREA_W'(-opb) : AREA_W'(opb);
   assign trial = {rem_ff, acc_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, mb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            neg_ff    <= opa[NUM_W-1] ^ opb[AREA_W-1];
            is_div_ff <= (op != OP_MUL);
            mb_ff     <= mbm;
            rem_ff    <= '0;
            mcand_ff  <= ma;
            unique case (op)
               OP_MUL: begin
                  acc_ff <= '0;
                  cnt_ff <= CNT_W'(AREA_W);
               end
               OP_DIV_SHORT: begin
                  acc_ff <= ma << (NUM_W - AREA_W);
                  cnt_ff <= CNT_W'(AREA_W);
               end
               default: begin
                  acc_ff <= ma;
                  cnt_ff <= CNT_W'(NUM_W);
               end
            endcase
         end else if (busy_ff) begin
            if (is_div_ff) begin
               rem_ff <= fits ? AREA_W'(trial - {1'b0, mb_ff}) : trial[AREA_W-1:0];
               acc_ff <= {acc_ff[NUM_W-2:0], fits};
            end else begin
               if (mb_ff[0]) begin
                  acc_ff <= acc_ff + mcand_ff;
               end
               mcand_ff <= mcand_ff << 1;
               mb_ff    <= mb_ff >> 1;
            end
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

// File: rtl/core/tcsd_datapath.sv
// ----------------------------------------------------------------------------
// tcsd_datapath
// corner store, x ordering, coordinate multiplier, iterative unit and
// result register
// ----------------------------------------------------------------------------
module tcsd_datapath #(
   parameter int DEPTH_FRAC_BITS = tcsd_pkg::DEPTH_FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcsd_pkg::cmd_type      cmd,
   output tcsd_pkg::stat_type     stat,
   input  tcsd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tcsd_pkg::rsp_word_type rsp_word
);
   import tcsd_pkg::*;

   localparam logic [DEPTH_BITS-1:0] DEPTH_TWO =
      DEPTH_BITS'(ZERO_AREA_DEPTH) << DEPTH_FRAC_BITS;
   localparam logic signed [NUM_W:0] SAT_HI = (NUM_W + 1)'(32'sh7fffffff);
   localparam logic signed [NUM_W:0] SAT_LO = ~SAT_HI;

   corner_type corner_ff [3];
   corner_type sa_ff, sb_ff, sc_ff;
   corner_type p0, p1, q1, q2, r0, r1;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic signed [COORD_BITS-1:0] y1_ff, y2_ff;
   logic signed [AREA_W-1:0]     t_ff, area_ff, na_ff, nb_ff;
   logic signed [NUM_W-1:0]      num_ff;
   rsp_word_type                 res_ff, rsp_ff;
   logic                         rsp_valid_ff;

   logic signed [DIFF_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]     prod;
   logic                         unit_start;
   logic [1:0]                   unit_op;
   logic signed [NUM_W-1:0]      unit_a;
   logic signed [AREA_W-1:0]     unit_b;
   logic                         unit_done;
   logic signed [NUM_W-1:0]      unit_q;
   logic signed [ZDIFF_W-1:0]    dza, dzb;
   logic signed [DIFF_W-1:0]     ysum_a, ysum_e2;
   logic signed [NUM_W:0]        zsum;
   logic signed [COORD_BITS-1:0] vmin, vmax, lo_in, hi_in;
   logic                         emit;

   // compare-swap network, swap only on strictly greater x
   always_comb begin
      p0 = corner_ff[0];
      p1 = corner_ff[1];
      if (corner_ff[0].x > corner_ff[1].x) begin
         p0 = corner_ff[1];
         p1 = corner_ff[0];
      end
      q1 = p1;
      q2 = corner_ff[2];
      if (p1.x > corner_ff[2].x) begin
         q1 = corner_ff[2];
         q2 = p1;
      end
      r0 = p0;
      r1 = q1;
      if (p0.x > q1.x) begin
         r0 = q1;
         r1 = p0;
      end
   end

   assign stat.outside   = (qx_ff < sa_ff.x) || (qx_ff > sc_ff.x);
   assign stat.vertical  = (sa_ff.x == sc_ff.x);
   assign stat.below_b   = (qx_ff < sb_ff.x);
   assign stat.b_eq_c    = (sb_ff.x == sc_ff.x);
   assign stat.area_zero = (area_ff == '0);
   assign stat.unit_done = unit_done;
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         ST_E1_MUL: begin
            mul_a = coord_diff(sc_ff.y, sa_ff.y);
            mul_b = coord_diff(qx_ff, sa_ff.x);
         end
         ST_E2_MUL: begin
            if (stat.below_b) begin
               mul_a = coord_diff(sb_ff.y, sa_ff.y);
               mul_b = coord_diff(qx_ff, sa_ff.x);
            end else begin
               mul_a = coord_diff(sb_ff.y, sc_ff.y);
               mul_b = coord_diff(qx_ff, sc_ff.x);
            end
         end
         ST_AREA1: begin
            mul_a = coord_diff(sb_ff.x, sa_ff.x);
            mul_b = coord_diff(sc_ff.y, sa_ff.y);
         end
         ST_AREA2: begin
            mul_a = coord_diff(sc_ff.x, sa_ff.x);
            mul_b = coord_diff(sb_ff.y, sa_ff.y);
         end
         ST_NA1: begin
            mul_a = coord_diff(sb_ff.x, qx_ff);
            mul_b = coord_diff(sc_ff.y, qy_ff);
         end
         ST_NA2: begin
            mul_a = coord_diff(sc_ff.x, qx_ff);
            mul_b = coord_diff(sb_ff.y, qy_ff);
         end
         ST_NB1: begin
            mul_a = coord_diff(sc_ff.x, qx_ff);
            mul_b = coord_diff(sa_ff.y, qy_ff);
         end
         ST_NB2: begin
            mul_a = coord_diff(sa_ff.x, qx_ff);
            mul_b = coord_diff(sc_ff.y, qy_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign dza  = ZDIFF_W'(sa_ff.z) - ZDIFF_W'(sc_ff.z);
   assign dzb  = ZDIFF_W'(sb_ff.z) - ZDIFF_W'(sc_ff.z);

   always_comb begin
      unit_start = 1'b0;
      unit_op    = OP_MUL;
      unit_a     = '0;
      unit_b     = '0;
      unique case (cmd.step)
         ST_E1_GO: begin
            unit_start = 1'b1;
            unit_op    = OP_DIV_SHORT;
            unit_a     = NUM_W'(t_ff);
            unit_b     = AREA_W'(coord_diff(sc_ff.x, sa_ff.x));
         end
         ST_E2_GO: begin
            unit_start = 1'b1;
            unit_op    = OP_DIV_SHORT;
            unit_a     = NUM_W'(t_ff);
            unit_b     = stat.below_b ? AREA_W'(coord_diff(sb_ff.x, sa_ff.x))
                                      : AREA_W'(coord_diff(sb_ff.x, sc_ff.x));
         end
         ST_ZA_GO: begin
            unit_start = 1'b1;
            unit_a     = NUM_W'(dza);
            unit_b     = na_ff;
         end
         ST_ZB_GO: begin
            unit_start = 1'b1;
            unit_a     = NUM_W'(dzb);
            unit_b     = nb_ff;
         end
         ST_DV_GO: begin
            unit_start = 1'b1;
            unit_op    = OP_DIV_LONG;
            unit_a     = num_ff;
            unit_b     = area_ff;
         end
         default: begin
            unit_start = 1'b0;
         end
      endcase
   end

   tcsd_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .op     (unit_op),
      .opa    (unit_a),
      .opb    (unit_b),
      .done   (unit_done),
      .result (unit_q)
   );

   assign ysum_a  = DIFF_W'(sa_ff.y) + $signed(unit_q[DIFF_W-1:0]);
   assign ysum_e2 = (stat.below_b ? DIFF_W'(sa_ff.y) : DIFF_W'(sc_ff.y))
                    + $signed(unit_q[DIFF_W-1:0]);
   assign zsum    = (NUM_W + 1)'(sc_ff.z) + (NUM_W + 1)'(unit_q);

   always_comb begin
      vmin = sa_ff.y;
      vmax = sa_ff.y;
      if (sb_ff.y < vmin) vmin = sb_ff.y;
      if (sc_ff.y < vmin) vmin = sc_ff.y;
      if (sb_ff.y > vmax) vmax = sb_ff.y;
      if (sc_ff.y > vmax) vmax = sc_ff.y;
   end

   assign lo_in = (y1_ff <= y2_ff) ? y1_ff : y2_ff;
   assign hi_in = (y1_ff <= y2_ff) ? y2_ff : y1_ff;
   assign emit  = (cmd.step == ST_EMIT) && !stat.out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            corner_ff[i] <= '0;
         end
      end else if (cmd.load && req_word.vertex_slot != SLOT_NONE) begin
         corner_ff[req_word.vertex_slot] <= '{x: req_word.vertex_x,
                                              y: req_word.vertex_y,
                                              z: req_word.vertex_depth};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff <= req_word.query_x;
         qy_ff <= req_word.query_y;
      end
      if (emit) begin
         rsp_ff <= res_ff;
      end
      unique case (cmd.step)
         ST_SORT: begin
            sa_ff <= r0;
            sb_ff <= r1;
            sc_ff <= q2;
         end
         ST_CHECK: begin
            res_ff.depth <= '0;
            if (stat.outside) begin
               res_ff.span_low  <= '0;
               res_ff.span_high <= '0;
               res_ff.status    <= STATUS_OUTSIDE;
            end else begin
               res_ff.span_low  <= vmin;
               res_ff.span_high <= vmax;
               res_ff.status    <= STATUS_OK;
            end
         end
         ST_E1_MUL: t_ff <= AREA_W'(prod);
         ST_E1_WAIT: begin
            if (unit_done) y1_ff <= ysum_a[COORD_BITS-1:0];
         end
         ST_E2_MUL: begin
            t_ff  <= AREA_W'(prod);
            y2_ff <= sb_ff.y;
         end
         ST_E2_WAIT: begin
            if (unit_done) y2_ff <= ysum_e2[COORD_BITS-1:0];
         end
         ST_SPAN: begin
            res_ff.span_low  <= lo_in;
            res_ff.span_high <= hi_in;
         end
         ST_AREA1, ST_NA1, ST_NB1: t_ff <= AREA_W'(prod);
         ST_AREA2: area_ff <= t_ff - AREA_W'(prod);
         ST_NA2:   na_ff   <= t_ff - AREA_W'(prod);
         ST_NB2:   nb_ff   <= t_ff - AREA_W'(prod);
         ST_ACHK: begin
            if (stat.area_zero) begin
               res_ff.depth  <= DEPTH_TWO;
               res_ff.status <= STATUS_FLAT;
            end
         end
         ST_ZA_WAIT: begin
            if (unit_done) num_ff <= unit_q;
         end
         ST_ZB_WAIT: begin
            if (unit_done) num_ff <= num_ff + unit_q;
         end
         ST_DV_WAIT: begin
            if (unit_done) begin
               if (zsum > SAT_HI) begin
                  res_ff.depth <= SAT_HI[DEPTH_BITS-1:0];
               end else if (zsum < SAT_LO) begin
                  res_ff.depth <= SAT_LO[DEPTH_BITS-1:0];
               end else begin
                  res_ff.depth <= zsum[DEPTH_BITS-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: rtl/core/tcsd_ctrl.sv
// ----------------------------------------------------------------------------
// tcsd_ctrl
// query sequencer: steps the datapath through ordering, edges, area,
// weights, depth quotient and result hand-off
// ----------------------------------------------------------------------------
module tcsd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   output logic               req_ready,
   input  tcsd_pkg::stat_type stat,
   output tcsd_pkg::cmd_type  cmd
);
   import tcsd_pkg::*;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid && req_mode == MODE_QUERY) state_in = ST_SORT;
         ST_SORT:    state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (stat.outside) state_in = ST_EMIT;
            else if (stat.vertical)    state_in = ST_AREA1;
            else                       state_in = ST_E1_MUL;
         end
         ST_E1_MUL:  state_in = ST_E1_GO;
         ST_E1_GO:   state_in = ST_E1_WAIT;
         ST_E1_WAIT: if (stat.unit_done) state_in = ST_E2_MUL;
         ST_E2_MUL:  state_in = (!stat.below_b && stat.b_eq_c) ? ST_SPAN : ST_E2_GO;
         ST_E2_GO:   state_in = ST_E2_WAIT;
         ST_E2_WAIT: if (stat.unit_done) state_in = ST_SPAN;
         ST_SPAN:    state_in = ST_AREA1;
         ST_AREA1:   state_in = ST_AREA2;
         ST_AREA2:   state_in = ST_ACHK;
         ST_ACHK:    state_in = stat.area_zero ? ST_EMIT : ST_NA1;
         ST_NA1:     state_in = ST_NA2;
         ST_NA2:     state_in = ST_NB1;
         ST_NB1:     state_in = ST_NB2;
         ST_NB2:     state_in = ST_ZA_GO;
         ST_ZA_GO:   state_in = ST_ZA_WAIT;
         ST_ZA_WAIT: if (stat.unit_done) state_in = ST_ZB_GO;
         ST_ZB_GO:   state_in = ST_ZB_WAIT;
         ST_ZB_WAIT: if (stat.unit_done) state_in = ST_DV_GO;
         ST_DV_GO:   state_in = ST_DV_WAIT;
         ST_DV_WAIT: if (stat.unit_done) state_in = ST_EMIT;
         ST_EMIT:    if (!stat.out_busy) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.load    = req_ready && req_valid && req_mode == MODE_LOAD;
   assign cmd.capture = req_ready && req_valid && req_mode == MODE_QUERY;
   assign cmd.step    = state_ff;

endmodule

// File: rtl/core/triangle_column_span_and_depth.sv
// load word: taken while the sequencer is idle, no result word
// query word: edges, area and depth computed on the shared one-bit-per-cycle
// multiply/divide unit; one query in flight, next word can be taken in the cycle after hand-off
// reset: synchronous active high, clears corners to zero, sequencer to idle
// and the result register to empty
// ----------------------------------------------------------------------------
// triangle_column_span_and_depth
// column span and interpolated depth of one stored screen triangle
// ----------------------------------------------------------------------------
module triangle_column_span_and_depth #(
   parameter int DEPTH_FRAC_BITS = tcsd_pkg::DEPTH_FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tcsd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tcsd_pkg::rsp_word_type rsp_word
);
   import tcsd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tcsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_word.mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tcsd_datapath #(
      .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives corner loads and column queries into the span and depth block and
// checks every result word against an in-bench integer predictor
// ----------------------------------------------------------------------------
class span_depth_board;
   tcsd_pkg::rsp_word_type pending[$];
   longint cx[3], cy[3], cz[3];
   int errors;

   function new();
      errors = 0;
      for (int i = 0; i < 3; i++) begin
         cx[i] = 0; cy[i] = 0; cz[i] = 0;
      end
   endfunction

   function longint edge_at(longint x0, longint y0, longint x1, longint y1, longint x);
      longint num;
      longint den;
      num = (y1 - y0) * (x - x0);
      den = x1 - x0;
      return y0 + num / den;
   endfunction

   function void note_word(tcsd_pkg::req_word_type w);
      longint ax, ay, az, bx, by, bz, qx, qy, tx, ty, tz;
      longint lo, hi, e1, e2, area, na, nb, num, d;
      tcsd_pkg::rsp_word_type r;
      if (w.mode == tcsd_pkg::MODE_LOAD) begin
         if (w.vertex_slot != tcsd_pkg::SLOT_NONE) begin
            cx[w.vertex_slot] = w.vertex_x;
            cy[w.vertex_slot] = w.vertex_y;
            cz[w.vertex_slot] = w.vertex_depth;
         end
         return;
      end
      ax = cx[0]; ay = cy[0]; az = cz[0];
      bx = cx[1]; by = cy[1]; bz = cz[1];
      tx = cx[2]; ty = cy[2]; tz = cz[2];
      if (ax > bx) begin
         {ax, bx} = {bx, ax}; {ay, by} = {by, ay}; {az, bz} = {bz, az};
      end
      if (bx > tx) begin
         {bx, tx} = {tx, bx}; {by, ty} = {ty, by}; {bz, tz} = {tz, bz};
      end
      if (ax > bx) begin
         {ax, bx} = {bx, ax}; {ay, by} = {by, ay}; {az, bz} = {bz, az};
      end
      qx = w.query_x;
      qy = w.query_y;
      if (qx < ax || qx > tx) begin
         r = '0;
         r.status = tcsd_pkg::STATUS_OUTSIDE;
         pending.push_back(r);
         return;
      end
      if (ax == tx) begin
         lo = ay; hi = ay;
         if (by < lo) lo = by;
         if (ty < lo) lo = ty;
         if (by > hi) hi = by;
         if (ty > hi) hi = ty;
      end else begin
         e1 = edge_at(ax, ay, tx, ty, qx);
         if (qx < bx) e2 = edge_at(ax, ay, bx, by, qx);
         else if (bx == tx) e2 = by;
         else e2 = edge_at(tx, ty, bx, by, qx);
         lo = (e1 <= e2) ? e1 : e2;
         hi = (e1 <= e2) ? e2 : e1;
      end
      area = (bx - ax) * (ty - ay) - (tx - ax) * (by - ay);
      r.status = tcsd_pkg::STATUS_OK;
      if (area == 0) begin
         d = longint'(tcsd_pkg::ZERO_AREA_DEPTH) << 16;
         r.status = tcsd_pkg::STATUS_FLAT;
      end else begin
         na = (bx - qx) * (ty - qy) - (tx - qx) * (by - qy);
         nb = (tx - qx) * (ay - qy) - (ax - qx) * (ty - qy);
         num = (az - tz) * na + (bz - tz) * nb;
         d = tz + num / area;
      end
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      r.span_low = lo[11:0];
      r.span_high = hi[11:0];
      r.depth = d[31:0];
      pending.push_back(r);
   endfunction

   function void check_word(tcsd_pkg::rsp_word_type got);
      tcsd_pkg::rsp_word_type exp_w;
      if (pending.size() == 0) begin
         $display("%0t unexpected result word %h", $realtime, got);
         errors++;
         return;
      end
      exp_w = pending.pop_front();
      if (got.span_low !== exp_w.span_low) begin
         $display("%0t span_low exp %0d got %0d", $realtime, exp_w.span_low, got.span_low);
         errors++;
      end
      if (got.span_high !== exp_w.span_high) begin
         $display("%0t span_high exp %0d got %0d", $realtime, exp_w.span_high,
                  got.span_high);
         errors++;
      end
      if (got.depth !== exp_w.depth) begin
         $display("%0t depth exp %h got %h", $realtime, exp_w.depth, got.depth);
         errors++;
      end
      if (got.status !== exp_w.status) begin
         $display("%0t status exp %0d got %0d", $realtime, exp_w.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb;
   import tcsd_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_word_type req_word;
   rsp_word_type rsp_word;

   span_depth_board board;
   int send_idle, recv_idle;
   bit hold_recv;
   int quiet_cycles;

   triangle_column_span_and_depth u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      send_idle = 0;
      recv_idle = 0;
      hold_recv = 1'b0;
   end

   // result side
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset) board.check_word(rsp_word);
         rsp_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("triangle_column_span_and_depth test failed");
            $finish;
         end
      end
   end

   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      board.note_word(w);
   endtask

   task automatic load_corner(int s, int x, int y, int z);
      req_word_type w;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(req_word_type)-1:0];
      w.mode = MODE_LOAD;
      w.vertex_slot = s[1:0];
      w.vertex_x = x[11:0];
      w.vertex_y = y[11:0];
      w.vertex_depth = z;
      send_word(w);
   endtask

   task automatic ask(int x, int y);
      req_word_type w;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(req_word_type)-1:0];
      w.mode = MODE_QUERY;
      w.query_x = x[11:0];
      w.query_y = y[11:0];
      send_word(w);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic int rcoord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic random_phase(int n);
      int tri_x[3];
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: load_corner($urandom_range(3), rcoord(2048), rcoord(2048), $urandom);
            1, 2: begin
               for (int k = 0; k < 3; k++) begin
                  tri_x[k] = ($urandom_range(7) == 0) ? rcoord(2048) : rcoord(60);
                  load_corner(k, tri_x[k], ($urandom_range(7) == 0) ? rcoord(2048) :
                              rcoord(60), ($urandom_range(3) == 0) ? $urandom :
                              rcoord(1 << 20));
               end
               i += 2;
            end
            3: load_corner($urandom_range(2), rcoord(8), rcoord(8), $urandom);
            default: begin
               if ($urandom_range(5) == 0) ask(rcoord(2048), rcoord(2048));
               else ask(int'(board.cx[$urandom_range(2)]) + rcoord(40), rcoord(80));
            end
         endcase
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      req_valid = 1'b0;
      req_word = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, extremes, vertical, right edge, flat, slot three
      ask(0, 0);
      ask(1, 0);
      load_corner(0, -2048, -2048, 32'sh8000_0000);
      load_corner(1, 2047, 2047, 32'sh7fff_ffff);
      load_corner(2, 2047, -2048, 0);
      ask(-2048, 2047);
      ask(2047, -2048);
      ask(0, 0);
      ask(-2048, -2048);
      load_corner(3, 5, 5, 5);
      ask(100, -100);
      load_corner(0, 10, 0, 1 << 16);
      load_corner(1, 10, 20, 2 << 16);
      load_corner(2, 10, -7, 3 << 16);
      ask(10, 3);
      ask(11, 3);
      load_corner(2, 30, 5, -1);
      ask(10, 5);
      ask(30, 5);
      load_corner(0, 0, 0, 7);
      load_corner(1, 5, 5, 7);
      load_corner(2, 10, 10, 7);
      ask(5, 5);
      req_valid <= 1'b0;
      drain();

      // receiver held off while the sender keeps going
      hold_recv = 1'b1;
      fork
         random_phase(40);
         begin
            repeat (3000) @(posedge clock);
            hold_recv = 1'b0;
         end
      join
      drain();

      send_idle = 19; recv_idle = 71;
      random_phase(600);
      drain();
      send_idle = 71; recv_idle = 19;
      random_phase(600);
      drain();
      send_idle = 0; recv_idle = 0;
      random_phase(640);
      drain();
      repeat (400) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("triangle_column_span_and_depth test passed");
      else
         $display("triangle_column_span_and_depth test failed");
      $finish;
   end
endmodule
